// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the diffuse term block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define LDT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define LDT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");
`else
`define LDT_ASSERT(lbl, clk, rst_n, prop)
`define LDT_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/ldt_pkg.sv
// ----------------------------------------------------------------------------
// ldt_pkg
// Types shared by the diffuse term pipeline modules.
// ----------------------------------------------------------------------------
package ldt_pkg;

  // Special cases that travel beside the arithmetic.
  typedef struct packed {
    logic zero;    // either vector has zero length
    logic nonpos;  // dot product is zero or negative
  } ldt_flags_t;

endpackage

// File: rtl/ldt_if.sv
// ----------------------------------------------------------------------------
// ldt_if
// Valid/ready channels for the vector pair input and the brightness output.
// ----------------------------------------------------------------------------
interface ldt_in_if #(parameter int CB = 16) ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] normal_x;
  logic signed [CB-1:0] normal_y;
  logic signed [CB-1:0] normal_z;
  logic signed [CB-1:0] light_x;
  logic signed [CB-1:0] light_y;
  logic signed [CB-1:0] light_z;
  modport source (output valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                  input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                output ready);
endinterface

interface ldt_out_if #(parameter int FB = 15) ();
  logic        valid;
  logic        ready;
  logic [FB:0] brightness;
  logic        zero_vector;
  modport source (output valid, brightness, zero_vector, input ready);
  modport sink (input valid, brightness, zero_vector, output ready);
endinterface

// File: rtl/ldt_lane.sv
// ----------------------------------------------------------------------------
// ldt_lane
// One axis: squares of both components and their cross product, registered.
// ----------------------------------------------------------------------------
module ldt_lane #(
  parameter int CB = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [CB-1:0]   n_i,
  input  logic signed [CB-1:0]   l_i,
  output logic [2*CB-1:0]        nn_o,
  output logic [2*CB-1:0]        ll_o,
  output logic signed [2*CB-1:0] nl_o
);
  logic signed [2*CB-1:0] nn_s, ll_s, nl_s;

  assign nn_s = n_i * n_i;
  assign ll_s = l_i * l_i;
  assign nl_s = n_i * l_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn_o <= $unsigned(nn_s);
      ll_o <= $unsigned(ll_s);
      nl_o <= nl_s;
    end
  end
endmodule

// File: rtl/ldt_sqrt.sv
// ----------------------------------------------------------------------------
// ldt_sqrt
// Pipelined restoring integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module ldt_sqrt #(
  parameter int W = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [2*W-1:0]            p_i,
  input  logic [W-1:0]              d_i,
  input  ldt_pkg::ldt_flags_t       flags_i,
  output logic                      valid_o,
  output logic [W-1:0]              s_o,
  output logic [W-1:0]              d_o,
  output ldt_pkg::ldt_flags_t       flags_o
);
  import ldt_pkg::*;

  localparam int RW = W + 3;

  logic             vld_q   [0:W];
  logic [RW-1:0]    rem_q   [0:W];
  logic [W-1:0]     root_q  [0:W];
  logic [2*W-1:0]   p_q     [0:W];
  logic [W-1:0]     d_q     [0:W];
  ldt_flags_t       flags_q [0:W];

  assign vld_q[0]   = valid_i;
  assign rem_q[0]   = '0;
  assign root_q[0]  = '0;
  assign p_q[0]     = p_i;
  assign d_q[0]     = d_i;
  assign flags_q[0] = flags_i;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [1:0]    pb;
    logic [RW-1:0] trial, tsub;
    logic          ge;

    assign pb    = p_q[k][2*W-1-2*k -: 2];
    // The remainder never exceeds twice the partial root, so its top bits are zero.
    assign trial = {rem_q[k][RW-3:0], pb};
    assign tsub  = RW'({root_q[k], 2'b01});
    assign ge    = trial >= tsub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]   <= ge ? trial - tsub : trial;
        root_q[k+1]  <= {root_q[k][W-2:0], ge};
        p_q[k+1]     <= p_q[k];
        d_q[k+1]     <= d_q[k];
        flags_q[k+1] <= flags_q[k];
      end
    end
  end

  assign valid_o = vld_q[W];
  assign s_o     = root_q[W];
  assign d_o     = d_q[W];
  assign flags_o = flags_q[W];
endmodule

// File: rtl/ldt_div.sv
// ----------------------------------------------------------------------------
// ldt_div
// Pipelined restoring divider giving the Q1.F cosine, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ldt_div #(
  parameter int W = 32,
  parameter int F = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [W-1:0]        d_i,
  input  logic [W-1:0]        s_i,
  input  ldt_pkg::ldt_flags_t flags_i,
  output logic                valid_o,
  output logic [F:0]          brightness_o,
  output logic                zero_o
);
  import ldt_pkg::*;

  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic         vld_q   [0:F+1];
  logic [W:0]   r_q     [0:F+1];
  logic [W-1:0] s_q     [0:F+1];
  logic [F:0]   q_q     [0:F+1];
  ldt_flags_t   flags_q [0:F+1];

  assign vld_q[0]   = valid_i;
  assign r_q[0]     = {1'b0, d_i};
  assign s_q[0]     = s_i;
  assign q_q[0]     = '0;
  assign flags_q[0] = flags_i;

  for (genvar k = 0; k <= F; k++) begin : g_stage
    logic [W:0] rin, rsub;
    logic       ge;

    // The first stage decides the integer bit without shifting.
    if (k == 0) begin : g_first
      assign rin = r_q[k];
    end else begin : g_next
      assign rin = {r_q[k][W-1:0], 1'b0};
    end
    assign ge   = rin >= {1'b0, s_q[k]};
    assign rsub = rin - {1'b0, s_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]     <= ge ? rsub : rin;
        s_q[k+1]     <= s_q[k];
        q_q[k+1]     <= {q_q[k][F-1:0], ge};
        flags_q[k+1] <= flags_q[k];
      end
    end
  end

  always_comb begin
    if (flags_q[F+1].zero || flags_q[F+1].nonpos) begin
      brightness_o = '0;
    end else if (q_q[F+1] > ONE) begin
      brightness_o = ONE;
    end else begin
      brightness_o = q_q[F+1];
    end
  end

  assign valid_o = vld_q[F+1];
  assign zero_o  = flags_q[F+1].zero;
endmodule

// File: rtl/lambert_diffuse_term_core.sv
// Throughput: one transaction per cycle while the output skid entry is empty; every stage is
// a fixed pipeline step. The pipeline length is set by the square root (one root bit per stage)
// and the divider (one quotient bit per stage). Reset clears all valid bits; data registers
// are not reset.
// ----------------------------------------------------------------------------
// lambert_diffuse_term_core
// Clamped cosine between a normal and a light vector in unsigned Q1.F.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lambert_diffuse_term_core #(
  parameter int COMPONENT_BITS = 16,
  parameter int FRACTION_BITS  = 15
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ldt_in_if.sink   req_i,
  ldt_out_if.source rsp_o
);
  import ldt_pkg::*;

  localparam int CB = COMPONENT_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int W  = 2 * CB;
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  // Per-axis lanes.
  logic signed [CB-1:0] n_in [0:2];
  logic signed [CB-1:0] l_in [0:2];
  logic [W-1:0]         nn_l [0:2];
  logic [W-1:0]         ll_l [0:2];
  logic signed [W-1:0]  nl_l [0:2];

  assign n_in[0] = req_i.normal_x;
  assign n_in[1] = req_i.normal_y;
  assign n_in[2] = req_i.normal_z;
  assign l_in[0] = req_i.light_x;
  assign l_in[1] = req_i.light_y;
  assign l_in[2] = req_i.light_z;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    ldt_lane #(.CB(CB)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (n_in[a]),
      .l_i   (l_in[a]),
      .nn_o  (nn_l[a]),
      .ll_o  (ll_l[a]),
      .nl_o  (nl_l[a])
    );
  end

  // Merge: squared lengths and dot product.
  logic [W+1:0]        nn_sum, ll_sum;
  logic signed [W+1:0] d_sum;
  logic [W-1:0]        nn_q, ll_q;
  logic signed [W:0]   d_q;

  assign nn_sum = {2'b00, nn_l[0]} + {2'b00, nn_l[1]} + {2'b00, nn_l[2]};
  assign ll_sum = {2'b00, ll_l[0]} + {2'b00, ll_l[1]} + {2'b00, ll_l[2]};
  assign d_sum  = (W+2)'(nl_l[0]) + (W+2)'(nl_l[1]) + (W+2)'(nl_l[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nn_q <= nn_sum[W-1:0];
      ll_q <= ll_sum[W-1:0];
      d_q  <= d_sum[W:0];
    end
  end

  // Partial products of |N|^2 * |L|^2 in halves.
  logic [W-1:0] pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [W-1:0] d3_q, d4_q;
  ldt_flags_t   flags3_q, flags4_q;
  logic [2*W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_hh_q         <= nn_q[W-1:CB] * ll_q[W-1:CB];
      pp_hl_q         <= nn_q[W-1:CB] * ll_q[CB-1:0];
      pp_lh_q         <= nn_q[CB-1:0] * ll_q[W-1:CB];
      pp_ll_q         <= nn_q[CB-1:0] * ll_q[CB-1:0];
      d3_q            <= d_q[W-1:0];
      flags3_q.zero   <= (nn_q == '0) || (ll_q == '0);
      flags3_q.nonpos <= d_q[W] || (d_q == '0);
      p_q             <= {pp_hh_q, pp_ll_q} + ((2*W)'(pp_hl_q) << CB)
                         + ((2*W)'(pp_lh_q) << CB);
      d4_q            <= d3_q;
      flags4_q        <= flags3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  logic         sq_valid;
  logic [W-1:0] sq_s, sq_d;
  ldt_flags_t   sq_flags;

  ldt_sqrt #(.W(W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4_q),
    .p_i     (p_q),
    .d_i     (d4_q),
    .flags_i (flags4_q),
    .valid_o (sq_valid),
    .s_o     (sq_s),
    .d_o     (sq_d),
    .flags_o (sq_flags)
  );

  logic        dv_valid;
  logic [FB:0] dv_bright;
  logic        dv_zero;

  ldt_div #(.W(W), .F(FB)) u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (sq_valid),
    .d_i          (sq_d),
    .s_i          (sq_s),
    .flags_i      (sq_flags),
    .valid_o      (dv_valid),
    .brightness_o (dv_bright),
    .zero_o       (dv_zero)
  );

  // Output register with a skid entry; the pipeline only stalls once the skid is full.
  logic        out_v_q, skid_v_q;
  logic [FB:0] out_b_q, skid_b_q;
  logic        out_z_q, skid_z_q;
  logic        out_free;

  assign en       = ~skid_v_q;
  assign out_free = ~out_v_q | rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (out_free) begin
          out_v_q  <= 1'b1;
          skid_v_q <= 1'b0;
        end
      end else if (dv_valid) begin
        if (out_free) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_b_q <= skid_b_q;
        out_z_q <= skid_z_q;
      end
    end else if (dv_valid) begin
      if (out_free) begin
        out_b_q <= dv_bright;
        out_z_q <= dv_zero;
      end else begin
        skid_b_q <= dv_bright;
        skid_z_q <= dv_zero;
      end
    end
  end

  assign req_i.ready       = en;
  assign rsp_o.valid       = out_v_q;
  assign rsp_o.brightness  = out_b_q;
  assign rsp_o.zero_vector = out_z_q;

  `LDT_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_v_q |-> out_v_q)
  `LDT_ASSERT(a_skid_holds, clk_i, rst_ni, (skid_v_q && !rsp_o.ready) |=> skid_v_q)
  `LDT_ASSERT_NEVER(a_zero_dark, clk_i, rst_ni, out_v_q && out_z_q && (out_b_q != '0))
  `LDT_ASSERT_NEVER(a_saturated, clk_i, rst_ni, out_v_q && (out_b_q > ONE))
endmodule

// File: dv/lambert_diffuse_term_core_test.sv
// ----------------------------------------------------------------------------
// lambert_diffuse_term_core_test
// Self-checking testbench for the diffuse cosine pipeline. A directed table
// of edge cases runs first, followed by random vector pairs. Every accepted
// transaction is predicted or taken from the table, then checked in order against
// the output. The sender runs in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module lambert_diffuse_term_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = 16;
  localparam int FB          = 15;
  localparam int ONE_Q       = 1 << FB;
  localparam int RAND_ITEMS  = 1700;
  localparam int DRAIN_WAIT  = 2 * CB + FB + 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CB-1:0] nx, ny, nz, lx, ly, lz;
  } vec_pair_t;

  typedef struct packed {
    logic [FB:0] brightness;
    logic        zero_vector;
  } shade_t;

  typedef struct packed {
    vec_pair_t vp;
    logic      typed;   // row carries a hand-written expectation
    shade_t    want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ldt_in_if  #(.CB(CB)) req ();
  ldt_out_if #(.FB(FB)) rsp ();

  lambert_diffuse_term_core #(
    .COMPONENT_BITS(CB),
    .FRACTION_BITS (FB)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  shade_t pending_shades[$];
  int     fails;
  int     checked;
  int     zero_hits;
  int     full_hits;
  int     cycles;

  // Exact integer cosine: dot * 2^FB / isqrt(|N|^2 |L|^2), clamped at 1.0.
  function automatic shade_t cosine_term(vec_pair_t v);
    shade_t      r;
    longint      nn, ll, d;
    bit [127:0]  prod, t;
    longint unsigned s, q;
    nn = longint'(v.nx) * v.nx + longint'(v.ny) * v.ny + longint'(v.nz) * v.nz;
    ll = longint'(v.lx) * v.lx + longint'(v.ly) * v.ly + longint'(v.lz) * v.lz;
    d  = longint'(v.nx) * v.lx + longint'(v.ny) * v.ly + longint'(v.nz) * v.lz;
    r = '0;
    if (nn == 0 || ll == 0) begin
      r.zero_vector = 1'b1;
      return r;
    end
    if (d <= 0) return r;
    prod = 128'(nn) * 128'(ll);
    s = 0;
    for (int b = 50; b >= 0; b--) begin
      t = 128'(s | (64'd1 << b));
      if (t * t <= prod) s = s | (64'd1 << b);
    end
    q = (longint'(d) << FB) / s;
    if (q > ONE_Q) q = ONE_Q;
    r.brightness = q[FB:0];
    return r;
  endfunction

  function automatic logic signed [CB-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return $signed(16'($urandom_range(0, 65535)));
      3:       return $signed(16'($urandom_range(0, 64) - 32));
      default: return $signed(16'($urandom_range(0, 8192) - 4096));
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t v;
    int        k;
    v = {rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    case ($urandom_range(0, 19))
      0: {v.nx, v.ny, v.nz} = '0;
      1: {v.lx, v.ly, v.lz} = '0;
      2, 3: begin
        // Light along a scaled (possibly negated) normal.
        v.nx = $signed(16'($urandom_range(0, 200) - 100));
        v.ny = $signed(16'($urandom_range(0, 200) - 100));
        v.nz = $signed(16'($urandom_range(0, 200) - 100));
        k = $urandom_range(1, 300) * ($urandom_range(0, 3) == 0 ? -1 : 1);
        v.lx = 16'(v.nx * k);
        v.ly = 16'(v.ny * k);
        v.lz = 16'(v.nz * k);
      end
      default: ;
    endcase
    return v;
  endfunction

  dir_row_t directed_rows[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd3}, 1'b1, '{16'd0, 1'b1}},
    '{'{16'sd5, -16'sd7, 16'sd9, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 1'b1}},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 1'b1}},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0}, 1'b1, '{16'd32768, 1'b0}},
    '{'{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 1'b0}},
    '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 1'b1, '{16'd0, 1'b0}},
    '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
      1'b1, '{16'd32768, 1'b0}},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
      1'b1, '{16'd32768, 1'b0}},
    '{'{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768},
      1'b1, '{16'd0, 1'b0}},
    '{'{16'sd3, 16'sd4, 16'sd0, 16'sd300, 16'sd400, 16'sd0}, 1'b1, '{16'd32768, 1'b0}},
    '{'{16'sd32767, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0}, 1'b0, '0},
    '{'{-16'sd32768, 16'sd32767, 16'sd1, 16'sd1, -16'sd1, 16'sd32767}, 1'b0, '0},
    '{'{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd0}, 1'b0, '0},
    '{'{16'sd1, 16'sd2, 16'sd3, 16'sd3, 16'sd2, 16'sd1}, 1'b0, '0},
    '{'{-16'sd1, -16'sd1, -16'sd1, 16'sd32767, -16'sd32768, -16'sd1}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd1, -16'sd1}, 1'b0, '0},
    '{'{16'sd100, 16'sd1, 16'sd0, 16'sd100, 16'sd0, 16'sd1}, 1'b0, '0}
  };

  // Drives one transaction and waits for it to be taken; valid stays high.
  task automatic send_pair(vec_pair_t v, logic typed, shade_t want);
    {req.normal_x, req.normal_y, req.normal_z,
     req.light_x, req.light_y, req.light_z} = v;
    req.valid = 1'b1;
    do @(posedge clk_i); while (!req.ready);
    pending_shades.push_back(typed ? want : cosine_term(v));
    if (pending_shades[$].zero_vector) zero_hits++;
    if (pending_shades[$].brightness == ONE_Q) full_hits++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int n);
    req.valid = 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Receiver: phases of always-ready, random stalls and a periodic stall.
  initial begin
    int mode;
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 2);
      for (int i = 0; i < 150; i++) begin
        @(negedge clk_i);
        case (mode)
          0:       rsp.ready = 1'b1;
          1:       rsp.ready = 1'($urandom_range(0, 1));
          default: rsp.ready = (i % 5) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    shade_t got, exp_s;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.brightness, rsp.zero_vector};
      if (pending_shades.size() == 0) begin
        $display("%0t: unexpected transaction, brightness %0d zero_vector %0b",
                 $realtime, got.brightness, got.zero_vector);
        fails++;
      end else begin
        exp_s = pending_shades.pop_front();
        checked++;
        if (got.brightness !== exp_s.brightness) begin
          $display("%0t: brightness expected %0d actual %0d",
                   $realtime, exp_s.brightness, got.brightness);
          fails++;
        end
        if (got.zero_vector !== exp_s.zero_vector) begin
          $display("%0t: zero_vector expected %0b actual %0b",
                   $realtime, exp_s.zero_vector, got.zero_vector);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, pending_shades.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int burst;
    bit drained;
    drained = 1'b0;
    req.valid = 1'b0;
    {req.normal_x, req.normal_y, req.normal_z, req.light_x, req.light_y, req.light_z} = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_pair(directed_rows[i].vp, directed_rows[i].typed, directed_rows[i].want);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end

    for (int n = 0; n < RAND_ITEMS;) begin
      if (n >= RAND_ITEMS / 2 && !drained) begin
        // Let the pipeline run completely dry once.
        idle_gap(1);
        while (pending_shades.size() != 0) @(negedge clk_i);
        drained = 1'b1;
      end
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++)
        send_pair(rand_pair(), 1'b0, '0);
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    req.valid = 1'b0;

    while (pending_shades.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d transactions: %0d with a zero-length vector, %0d at full 1.0.",
             checked, zero_hits, full_hits);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fails);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
